// File: sv/apq_pkg.sv
`timescale 1ns / 1ps

package apq_pkg;

	typedef struct packed {
		logic [31:0] val;
		logic [15:0] pri;
	} entry_t;

	typedef enum logic [1:0] {
		KIND_ENQ  = 2'd0,
		KIND_DEQ  = 2'd1,
		KIND_UPD  = 2'd2,
		KIND_FIND = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

endpackage

// File: sv/apq_ram.sv
`timescale 1ns / 1ps

module apq_ram #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  apq_pkg::entry_t wr_data,
	input  logic [AW-1:0]   rd_addr,
	output apq_pkg::entry_t rd_data
);
	import apq_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/array_priority_queue.sv
`timescale 1ns / 1ps
// Enqueue, update and any op on an empty queue go from idle straight to the done state, then to the result register.
// Find: scans from position 0 to a match or the last entry, one store read per cycle through a single compare unit.
// Dequeue: a scan of all entries for the highest priority, then a shift-down of those above it, one entry a cycle.
// One item at a time; s_tready is high only while idle. A finished result may wait in m_*.
// arst_n clears the entry count and the handshakes; the store itself is never cleared.
module array_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // [1:0] kind
	input  logic [55:0] s_tdata,   // [31:0] item_value, [47:32] item_priority, [51:48] slot_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic [63:0] m_tdata    // [31:0] result_value, [47:32] result_priority,
	                               // [51:48] result_index, [56:52] entry_count
);
	import apq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	kind_t       op_q;
	logic [31:0] val_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_q;
	logic          rv_q;
	logic [AW-1:0] ri_q;
	entry_t        best_q;
	logic [AW-1:0] best_idx_q;

	status_t     res_status_q;
	logic [31:0] res_val_q;
	logic [15:0] res_pri_q;
	logic [3:0]  res_idx_q;

	logic        m_tvalid_q;
	status_t     m_tuser_q;
	logic [63:0] m_tdata_q;

	// ram side
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic [AW-1:0] rd_addr;
	entry_t        rdata;

	kind_t       in_kind;
	logic [31:0] in_val;
	logic [15:0] in_pri;
	logic [3:0]  in_slot;

	logic          accept, issue, out_free, load_out;
	logic          cnt_full, cnt_empty, slot_bad;
	logic [AW-1:0] cnt_last;
	logic          last_data, dq_take, find_hit, scan_done, shift_done;
	entry_t        best_nx;
	logic [AW-1:0] best_idx_nx;

	assign in_kind = kind_t'(s_tuser);
	assign in_val  = s_tdata[31:0];
	assign in_pri  = s_tdata[47:32];
	assign in_slot = s_tdata[51:48];

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cnt_full  = (32'(cnt_q) >= 32'(CAPACITY));
	assign cnt_empty = (cnt_q == '0);
	assign slot_bad  = (32'(in_slot) >= 32'(cnt_q));
	assign cnt_last  = AW'(cnt_q - CW'(1));

	// shared compare unit: data returning from the store against the running best or the key
	assign last_data   = rv_q && (ri_q == cnt_last);
	assign dq_take     = rv_q && ((ri_q == '0) || (rdata.pri > best_q.pri));
	assign best_nx     = dq_take ? rdata : best_q;
	assign best_idx_nx = dq_take ? ri_q : best_idx_q;
	assign find_hit    = rv_q && (rdata.val == val_q);
	assign scan_done   = (op_q == KIND_FIND) ? (find_hit || last_data) : last_data;
	assign shift_done  = (rd_q >= cnt_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if ((in_kind == KIND_DEQ || in_kind == KIND_FIND) && !cnt_empty)
						state_d = S_SCAN;
					else
						state_d = S_DONE;
				end
			end
			S_SCAN: begin
				if (scan_done)
					state_d = (op_q == KIND_DEQ) ? S_SHIFT : S_DONE;
			end
			S_SHIFT: begin
				if (shift_done)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '{val: in_val, pri: in_pri};
		rd_addr  = AW'(rd_q);
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (accept && in_kind == KIND_ENQ && !cnt_full) begin
					wr_en   = 1'b1;
					wr_addr = AW'(cnt_q);
				end else if (accept && in_kind == KIND_UPD && !cnt_empty && !slot_bad) begin
					wr_en   = 1'b1;
					wr_addr = AW'(in_slot);
				end
			end
			S_SCAN: begin
				issue = (rd_q < cnt_q);
			end
			S_SHIFT: begin
				issue = (rd_q < cnt_q);
				// entry read last cycle moves down one place
				if (rv_q) begin
					wr_en   = 1'b1;
					wr_addr = ri_q - AW'(1);
					wr_data = rdata;
				end
			end
			S_DONE: begin
				load_out = out_free;
			end
			default: ;
		endcase
	end

	apq_ram #(.DEPTH(CAPACITY)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			rv_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_q    <= issue;
			if (accept && in_kind == KIND_ENQ && !cnt_full)
				cnt_q <= cnt_q + CW'(1);
			else if (state_q == S_SHIFT && shift_done)
				cnt_q <= cnt_q - CW'(1);
			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_q <= rd_q + CW'(1);
			ri_q <= AW'(rd_q);
		end
		if (accept) begin
			op_q         <= in_kind;
			val_q        <= in_val;
			rd_q         <= '0;
			res_status_q <= ST_OK;
			res_val_q    <= '0;
			res_pri_q    <= '0;
			res_idx_q    <= '0;
			case (in_kind)
				KIND_ENQ: begin
					if (cnt_full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_val_q <= in_val;
						res_pri_q <= in_pri;
						res_idx_q <= 4'(cnt_q);
					end
				end
				KIND_UPD: begin
					if (cnt_empty) begin
						res_status_q <= ST_EMPTY;
					end else if (slot_bad) begin
						res_status_q <= ST_RANGE;
						res_idx_q    <= in_slot;
					end else begin
						res_val_q <= in_val;
						res_pri_q <= in_pri;
						res_idx_q <= in_slot;
					end
				end
				default: begin
					if (cnt_empty)
						res_status_q <= ST_EMPTY;
				end
			endcase
		end
		if (state_q == S_SCAN) begin
			if (op_q == KIND_DEQ && rv_q) begin
				best_q     <= best_nx;
				best_idx_q <= best_idx_nx;
			end
			if (scan_done) begin
				if (op_q == KIND_DEQ) begin
					rd_q <= CW'(best_idx_nx) + CW'(1);
				end else if (find_hit) begin
					res_status_q <= ST_OK;
					res_val_q    <= rdata.val;
					res_pri_q    <= rdata.pri;
					res_idx_q    <= 4'(ri_q);
				end else begin
					res_status_q <= ST_NOTFOUND;
				end
			end
		end
		if (state_q == S_SHIFT && shift_done) begin
			res_status_q <= ST_OK;
			res_val_q    <= best_q.val;
			res_pri_q    <= best_q.pri;
			res_idx_q    <= 4'(best_idx_q);
		end
		if (load_out) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= {7'b0, 5'(cnt_q), res_idx_q, res_pri_q, res_val_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: sv/apq_check.sv
`timescale 1ns / 1ps

module apq_check #(
	parameter int CAPACITY = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [2:0]  m_tuser,
	input logic [63:0] m_tdata
);
	import apq_pkg::*;

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item in flight: no transfer right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == 3'(ST_FULL) |-> m_tdata[56:52] == 5'(CAPACITY))
		else $error("full status with count below capacity");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == 3'(ST_EMPTY) |-> m_tdata[56:0] == '0)
		else $error("empty status with nonzero fields");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CAPACITY > 31) || (m_tdata[56:52] <= CAPACITY))
		else $error("count above capacity");

endmodule

bind array_priority_queue apq_check #(.CAPACITY(CAPACITY)) u_apq_check (.*);

// File: sim/tb_array_priority_queue.sv
`timescale 1ns / 1ps

module tb_array_priority_queue;
	import apq_pkg::*;

	localparam int CAPACITY     = 16;
	localparam int RAND_ITEMS   = 1420;
	localparam int CALM_ITEMS   = 200;
	localparam int DRAIN_CYCLES = 48;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int NUM_ROWS     = 20;

	typedef struct packed {
		status_t     st;
		logic [31:0] val;
		logic [15:0] pri;
		logic [3:0]  idx;
		logic [4:0]  cnt;
	} pq_result_t;

	typedef struct {
		kind_t       kind;
		logic [31:0] val;
		logic [15:0] pri;
		logic [3:0]  slot;
		int          reps;
		bit          typed;
		pq_result_t  res;
	} op_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;   // [1:0] kind
	logic [55:0] s_tdata = '0;   // [31:0] item_value, [47:32] item_priority, [51:48] slot_index
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [2:0]  m_tuser;        // [2:0] status
	logic [63:0] m_tdata;        // [31:0] result_value, [47:32] result_priority,
	                             // [51:48] result_index, [56:52] entry_count

	// shadow copy of the queue contents
	entry_t     shadow_entries [CAPACITY];
	int         shadow_fill = 0;
	pq_result_t awaited_results [$];
	op_row_t    op_rows [NUM_ROWS];

	bit         calm_tail = 1'b0;
	int         fail_count = 0;
	int         cycle_count = 0;
	int         kind_seen [4] = '{0, 0, 0, 0};
	int         status_seen [5] = '{0, 0, 0, 0, 0};
	pq_result_t want;

	array_priority_queue #(.CAPACITY(CAPACITY)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				awaited_results.size());
			$display("tb_array_priority_queue: FAIL");
			$finish;
		end
	end

	function automatic pq_result_t apply_queue_op(kind_t k, logic [31:0] v, logic [15:0] p,
			logic [3:0] slot);
		pq_result_t res;
		int best;
		int j;
		res = '{ST_OK, 32'h0, 16'h0, 4'h0, 5'h0};
		case (k)
			KIND_ENQ: begin
				if (shadow_fill >= CAPACITY) begin
					res.st = ST_FULL;
				end else begin
					shadow_entries[shadow_fill] = '{v, p};
					res.val = v;
					res.pri = p;
					res.idx = shadow_fill[3:0];
					shadow_fill++;
				end
			end
			KIND_DEQ: begin
				if (shadow_fill == 0) begin
					res.st = ST_EMPTY;
				end else begin
					// strict compare: ties stay with the lowest position
					best = 0;
					for (j = 1; j < shadow_fill; j++)
						if (shadow_entries[j].pri > shadow_entries[best].pri)
							best = j;
					res.val = shadow_entries[best].val;
					res.pri = shadow_entries[best].pri;
					res.idx = best[3:0];
					for (j = best; j + 1 < shadow_fill; j++)
						shadow_entries[j] = shadow_entries[j + 1];
					shadow_fill--;
				end
			end
			KIND_UPD: begin
				if (shadow_fill == 0) begin
					res.st = ST_EMPTY;
				end else if (int'(slot) >= shadow_fill) begin
					res.st = ST_RANGE;
					res.idx = slot;
				end else begin
					shadow_entries[slot] = '{v, p};
					res.val = v;
					res.pri = p;
					res.idx = slot;
				end
			end
			default: begin
				if (shadow_fill == 0) begin
					res.st = ST_EMPTY;
				end else begin
					res.st = ST_NOTFOUND;
					for (j = 0; j < shadow_fill; j++) begin
						if (res.st == ST_NOTFOUND && shadow_entries[j].val == v) begin
							res.st = ST_OK;
							res.val = shadow_entries[j].val;
							res.pri = shadow_entries[j].pri;
							res.idx = j[3:0];
						end
					end
				end
			end
		endcase
		res.cnt = shadow_fill[4:0];
		return res;
	endfunction

	// drive one op, wait for its transfer, then queue what the block should answer
	task automatic push_item(kind_t k, logic [31:0] v, logic [15:0] p, logic [3:0] slot,
			bit typed, pq_result_t typed_res);
		pq_result_t res;
		if (!calm_tail && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {4'h0, slot, p, v};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		res = apply_queue_op(k, v, p, slot);
		if (typed)
			res = typed_res;
		awaited_results.push_back(res);
		kind_seen[int'(k)]++;
		status_seen[int'(res.st)]++;
	endtask

	initial begin : sink
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
			if (!calm_tail && $urandom_range(0, 1) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: status %0d data %h", m_tuser, m_tdata);
			end else begin
				want = awaited_results.pop_front();
				if (m_tuser != want.st || m_tdata[31:0] != want.val
						|| m_tdata[47:32] != want.pri || m_tdata[51:48] != want.idx
						|| m_tdata[56:52] != want.cnt) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch st/val/pri/idx/cnt: exp %0d/%h/%h/%0d/%0d, got %0d/%h/%h/%0d/%0d",
							want.st, want.val, want.pri, want.idx, want.cnt,
							m_tuser, m_tdata[31:0], m_tdata[47:32], m_tdata[51:48],
							m_tdata[56:52]);
				end
			end
		end
	end

	initial begin : stim
		int i;
		int n;
		int r;
		bit fill_phase;
		kind_t k;
		logic [31:0] v;
		logic [15:0] p;
		logic [3:0] slot;

		op_rows = '{
			// empty queue: every op but enqueue reports empty
			'{KIND_DEQ,  32'h0,        16'h0,    4'h0,  1, 1'b1,
				'{ST_EMPTY,    32'h0,        16'h0,    4'h0, 5'd0}},
			'{KIND_UPD,  32'h1234,     16'h5,    4'h0,  1, 1'b1,
				'{ST_EMPTY,    32'h0,        16'h0,    4'h0, 5'd0}},
			'{KIND_FIND, 32'h0,        16'h0,    4'h0,  1, 1'b1,
				'{ST_EMPTY,    32'h0,        16'h0,    4'h0, 5'd0}},
			// zero priority is still served, ties to the lowest position
			'{KIND_ENQ,  32'h9,        16'h0,    4'h0,  1, 1'b1,
				'{ST_OK,       32'h9,        16'h0,    4'h0, 5'd1}},
			'{KIND_ENQ,  32'hA,        16'h0,    4'h0,  1, 1'b1,
				'{ST_OK,       32'hA,        16'h0,    4'h1, 5'd2}},
			'{KIND_DEQ,  32'h0,        16'h0,    4'h0,  1, 1'b1,
				'{ST_OK,       32'h9,        16'h0,    4'h0, 5'd1}},
			'{KIND_DEQ,  32'h0,        16'h0,    4'h0,  1, 1'b1,
				'{ST_OK,       32'hA,        16'h0,    4'h0, 5'd0}},
			// value and priority extremes
			'{KIND_ENQ,  32'h80000000, 16'h0,    4'h0,  1, 1'b1,
				'{ST_OK,       32'h80000000, 16'h0,    4'h0, 5'd1}},
			'{KIND_ENQ,  32'h7FFFFFFF, 16'hFFFF, 4'h0,  1, 1'b1,
				'{ST_OK,       32'h7FFFFFFF, 16'hFFFF, 4'h1, 5'd2}},
			'{KIND_ENQ,  32'h5,        16'hFFFF, 4'h0,  1, 1'b1,
				'{ST_OK,       32'h5,        16'hFFFF, 4'h2, 5'd3}},
			// update past the count, then at the edge of it
			'{KIND_UPD,  32'hDEAD,     16'h11,   4'hF,  1, 1'b1,
				'{ST_RANGE,    32'h0,        16'h0,    4'hF, 5'd3}},
			'{KIND_UPD,  32'hBEEF,     16'h22,   4'h3,  1, 1'b1,
				'{ST_RANGE,    32'h0,        16'h0,    4'h3, 5'd3}},
			'{KIND_UPD,  32'hFFFFFFFF, 16'h1,    4'h0,  1, 1'b1,
				'{ST_OK,       32'hFFFFFFFF, 16'h1,    4'h0, 5'd3}},
			'{KIND_FIND, 32'h5,        16'h0,    4'h0,  1, 1'b1,
				'{ST_OK,       32'h5,        16'hFFFF, 4'h2, 5'd3}},
			'{KIND_FIND, 32'h7B,       16'h0,    4'h0,  1, 1'b1,
				'{ST_NOTFOUND, 32'h0,        16'h0,    4'h0, 5'd3}},
			'{KIND_DEQ,  32'h0,        16'h0,    4'h0,  1, 1'b1,
				'{ST_OK,       32'h7FFFFFFF, 16'hFFFF, 4'h1, 5'd2}},
			// fill to capacity with duplicates, then push once more
			'{KIND_ENQ,  32'h100,      16'h7,    4'h0, 14, 1'b0,
				'{ST_OK,       32'h0,        16'h0,    4'h0, 5'd0}},
			'{KIND_ENQ,  32'h200,      16'h9,    4'h0,  1, 1'b1,
				'{ST_FULL,     32'h0,        16'h0,    4'h0, 5'd16}},
			'{KIND_FIND, 32'h100,      16'h0,    4'h0,  1, 1'b1,
				'{ST_OK,       32'h100,      16'h7,    4'h2, 5'd16}},
			'{KIND_UPD,  32'h300,      16'hFFFF, 4'hF,  1, 1'b1,
				'{ST_OK,       32'h300,      16'hFFFF, 4'hF, 5'd16}}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (op_rows[i])
			for (n = 0; n < op_rows[i].reps; n++)
				push_item(op_rows[i].kind, op_rows[i].val, op_rows[i].pri, op_rows[i].slot,
					op_rows[i].typed, op_rows[i].res);

		// alternate fill-leaning and drain-leaning stretches so full and empty recur
		fill_phase = 1'b0;
		for (i = 0; i < RAND_ITEMS; i++) begin
			if (i % 80 == 0 && i != 0)
				fill_phase = !fill_phase;
			if (i == RAND_ITEMS - CALM_ITEMS)
				calm_tail = 1'b1;

			r = $urandom_range(0, 99);
			if (fill_phase)
				k = (r < 55) ? KIND_ENQ : (r < 75) ? KIND_DEQ : (r < 88) ? KIND_UPD : KIND_FIND;
			else
				k = (r < 25) ? KIND_ENQ : (r < 70) ? KIND_DEQ : (r < 85) ? KIND_UPD : KIND_FIND;

			r = $urandom_range(0, 9);
			if (r < 3)
				v = $urandom_range(0, 7);
			else if (r == 3)
				case ($urandom_range(0, 3))
					0: v = 32'h80000000;
					1: v = 32'h7FFFFFFF;
					2: v = 32'hFFFFFFFF;
					default: v = 32'h0;
				endcase
			else
				v = $urandom;
			if (k == KIND_FIND && shadow_fill > 0 && $urandom_range(0, 9) < 6)
				v = shadow_entries[$urandom_range(0, shadow_fill - 1)].val;

			r = $urandom_range(0, 9);
			if (r < 4)
				p = 16'($urandom_range(0, 3));
			else if (r == 4)
				p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
			else
				p = 16'($urandom);

			if (k == KIND_UPD && shadow_fill > 0 && $urandom_range(0, 3) != 0)
				slot = 4'($urandom_range(0, shadow_fill - 1));
			else
				slot = 4'($urandom_range(0, 15));

			push_item(k, v, p, slot, 1'b0, '{ST_OK, 32'h0, 16'h0, 4'h0, 5'd0});
		end
		s_tvalid <= 1'b0;

		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ops: %0d enqueue, %0d dequeue, %0d update, %0d find",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
		$display("status: ok %0d, full %0d, empty %0d, range %0d, not found %0d; %0d mismatches",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
			fail_count);
		if (fail_count == 0) begin
			$display("tb_array_priority_queue: PASS");
		end else begin
			$display("tb_array_priority_queue: FAIL");
		end
		$finish;
	end

endmodule
